// ===== rtl/spf_pkg.sv =====
// ---------------------------------------------------------------------------
// spf_pkg: shared definitions for the scanline span fill unit
// Field widths, item codes, edge record and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package spf_pkg;

  // field widths
  localparam int FUNC_W = 2;
  localparam int Y_W    = 10;
  localparam int X_W    = 18;
  localparam int DX_W   = 17;

  // default edge table depth
  localparam int MAX_EDGES_DEF = 8;

  // item codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP    = 2'd2;

  // saturation bounds of a running x
  localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
  localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};

  // one stored edge
  typedef struct packed {
    logic signed [Y_W-1:0]  lo_y;
    logic signed [X_W-1:0]  x0;
    logic signed [Y_W-1:0]  hi_y;
    logic signed [DX_W-1:0] dx;
  } edge_rec_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    logic proc;
    logic finish;
  } spf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } spf_stat_t;

endpackage

// ===== rtl/spf_if.sv =====
// ---------------------------------------------------------------------------
// spf_in_if / spf_out_if: item channels of the span fill unit
// Valid/ready channels carrying the input item and the span result item.
// ---------------------------------------------------------------------------
interface spf_in_if;
  import spf_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FUNC_W-1:0]      func;
  logic signed [Y_W-1:0]  edge_lower_y;
  logic signed [X_W-1:0]  edge_start_x;
  logic signed [Y_W-1:0]  edge_upper_y;
  logic signed [DX_W-1:0] edge_slope;
  logic signed [Y_W-1:0]  start_y;

  modport source (output valid, func, edge_lower_y, edge_start_x, edge_upper_y,
                  edge_slope, start_y, input ready);
  modport sink (input valid, func, edge_lower_y, edge_start_x, edge_upper_y,
                edge_slope, start_y, output ready);
endinterface

interface spf_out_if;
  import spf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [Y_W-1:0] span_y;
  logic signed [X_W-1:0] span_left;
  logic signed [X_W-1:0] span_right;
  logic                  span_valid;
  logic                  fill_done;

  modport source (output valid, span_y, span_left, span_right, span_valid,
                  fill_done, input ready);
  modport sink (input valid, span_y, span_left, span_right, span_valid,
                fill_done, output ready);
endinterface

// ===== rtl/spf_ctrl.sv =====
// ---------------------------------------------------------------------------
// spf_ctrl: sequencer of the span fill unit
// Accepts items, walks the edge table one entry a cycle for a step and
// hands the finished span to the output register.
// ---------------------------------------------------------------------------
module spf_ctrl #(
  parameter int MAX_EDGES = spf_pkg::MAX_EDGES_DEF,
  parameter int IDX_W     = $clog2(MAX_EDGES),
  parameter int CNT_W     = $clog2(MAX_EDGES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [spf_pkg::FUNC_W-1:0] in_func,
  output logic                      in_ready,
  input  logic [CNT_W-1:0]          edge_count,
  input  spf_pkg::spf_stat_t        stat,
  output spf_pkg::spf_cmd_t         cmd,
  output logic [IDX_W-1:0]          idx
);
  import spf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;
  logic             last;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last     = (CNT_W'(idx_r) == edge_count - CNT_W'(1));
  assign idx      = idx_r;

  // commands
  always_comb begin
    cmd.load    = accept && (in_func == FUNC_LOAD);
    cmd.restart = accept && (in_func == FUNC_RESTART);
    cmd.start   = accept && (in_func == FUNC_STEP);
    cmd.proc    = (state_r == S_SCAN);
    cmd.finish  = (state_r == S_DONE) && stat.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          idx_nxt   = '0;
          state_nxt = (edge_count == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ===== rtl/spf_dpath.sv =====
// ---------------------------------------------------------------------------
// spf_dpath: datapath of the span fill unit
// Edge table and running x memories, active marks, crossing selection,
// x update with saturation and the result register.
// ---------------------------------------------------------------------------
module spf_dpath #(
  parameter int MAX_EDGES = spf_pkg::MAX_EDGES_DEF,
  parameter int IDX_W     = $clog2(MAX_EDGES),
  parameter int CNT_W     = $clog2(MAX_EDGES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spf_pkg::spf_cmd_t            cmd,
  input  logic [IDX_W-1:0]             idx,
  output spf_pkg::spf_stat_t           stat,
  output logic [CNT_W-1:0]             edge_count,
  input  logic signed [spf_pkg::Y_W-1:0]  in_edge_lower_y,
  input  logic signed [spf_pkg::X_W-1:0]  in_edge_start_x,
  input  logic signed [spf_pkg::Y_W-1:0]  in_edge_upper_y,
  input  logic signed [spf_pkg::DX_W-1:0] in_edge_slope,
  input  logic signed [spf_pkg::Y_W-1:0]  in_start_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [spf_pkg::Y_W-1:0]  out_span_y,
  output logic signed [spf_pkg::X_W-1:0]  out_span_left,
  output logic signed [spf_pkg::X_W-1:0]  out_span_right,
  output logic                         out_span_valid,
  output logic                         out_fill_done
);
  import spf_pkg::*;

  // storage
  edge_rec_t             edge_mem [MAX_EDGES];
  logic signed [X_W-1:0] ax_mem   [MAX_EDGES];
  edge_rec_t             edge_rd_r;
  logic signed [X_W-1:0] ax_rd_r;
  logic [MAX_EDGES-1:0]  mark_r;
  logic [CNT_W-1:0]      count_r;
  logic signed [Y_W-1:0] cur_y_r;
  logic signed [Y_W-1:0] high_y_r;

  // crossing capture
  logic [1:0]            found_r;
  logic signed [X_W-1:0] xs0_r, xs1_r;

  // result register
  logic                  oval_r;
  logic signed [Y_W-1:0] o_y_r;
  logic signed [X_W-1:0] o_left_r, o_right_r;
  logic                  o_sv_r, o_fd_r;

  logic [IDX_W-1:0]      raddr;
  logic                  can_load;
  logic                  act, mk, hit;
  logic signed [X_W-1:0] xsel, xupd;
  logic signed [X_W:0]   xsum;
  logic signed [Y_W:0]   next_y;
  logic                  sv;

  assign edge_count   = count_r;
  assign stat.out_free = !oval_r || out_ready;
  assign can_load     = (count_r < CNT_W'(MAX_EDGES));

  // read address: entry 0 at step start, then one ahead of the processed entry
  assign raddr = cmd.start ? '0 : idx + IDX_W'(1);

  // per-edge activation, selection and update
  always_comb begin
    act  = (edge_rd_r.lo_y == cur_y_r);
    mk   = mark_r[idx] || act;
    xsel = act ? edge_rd_r.x0 : ax_rd_r;
    hit  = mk && (edge_rd_r.hi_y > cur_y_r);
    xsum = {xsel[X_W-1], xsel} + {{(X_W+1-DX_W){edge_rd_r.dx[DX_W-1]}}, edge_rd_r.dx};
    if (xsum[X_W] != xsum[X_W-1]) xupd = xsum[X_W] ? X_MIN : X_MAX;
    else                          xupd = xsum[X_W-1:0];
  end

  // span validity and scanline advance
  assign sv     = (found_r == 2'd2);
  assign next_y = {cur_y_r[Y_W-1], cur_y_r} + (Y_W+1)'(1);

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load && can_load) begin
      edge_mem[count_r[IDX_W-1:0]] <= '{lo_y: in_edge_lower_y, x0: in_edge_start_x,
                                        hi_y: in_edge_upper_y, dx: in_edge_slope};
    end
    if (cmd.proc && mk) ax_mem[idx] <= xupd;
    edge_rd_r <= edge_mem[raddr];
    ax_rd_r   <= ax_mem[raddr];
  end

  // control state: marks, count, scanline, highest y, crossing count, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r   <= '0;
      count_r  <= '0;
      cur_y_r  <= '0;
      high_y_r <= '0;
      found_r  <= '0;
      oval_r   <= 1'b0;
    end else begin
      if (cmd.load && can_load) begin
        mark_r[count_r[IDX_W-1:0]] <= 1'b0;
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.restart) begin
        mark_r  <= '0;
        cur_y_r <= in_start_y;
      end
      if (cmd.start) found_r <= '0;
      if (cmd.proc) begin
        if (act) begin
          mark_r[idx] <= 1'b1;
          if (edge_rd_r.hi_y > high_y_r) high_y_r <= edge_rd_r.hi_y;
        end
        if (hit && !found_r[1]) found_r <= found_r + 2'd1;
      end
      if (cmd.finish) cur_y_r <= next_y[Y_W-1:0];
      if (cmd.finish)          oval_r <= 1'b1;
      else if (out_ready)      oval_r <= 1'b0;
    end
  end

  // crossing x capture
  always_ff @(posedge clk) begin
    if (cmd.proc && hit && !found_r[1]) begin
      if (found_r == 2'd0) xs0_r <= xsel;
      else                 xs1_r <= xsel;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_y_r     <= cur_y_r;
      o_sv_r    <= sv;
      o_left_r  <= !sv ? '0 : ((xs0_r < xs1_r) ? xs0_r : xs1_r);
      o_right_r <= !sv ? '0 : ((xs0_r < xs1_r) ? xs1_r : xs0_r);
      o_fd_r    <= (next_y > $signed({high_y_r[Y_W-1], high_y_r}));
    end
  end

  assign out_valid      = oval_r;
  assign out_span_y     = o_y_r;
  assign out_span_left  = o_left_r;
  assign out_span_right = o_right_r;
  assign out_span_valid = o_sv_r;
  assign out_fill_done  = o_fd_r;

endmodule

// ===== rtl/scanline_polygon_span_fill_unit.sv =====
// Load and restart items are taken in the idle state; the next item is accepted
// right after. A step item reads one stored edge per cycle through the single
// read port of the edge table, between read start and result load, and is held
// while an earlier span waits. Synchronous active-low reset empties the edge
// table, clears all active marks and sets the current and highest scanline to zero.
// ---------------------------------------------------------------------------
// scanline_polygon_span_fill_unit: scanline polygon span fill
// Edge table with active edge marks; emits one ordered span per step item.
// ---------------------------------------------------------------------------
module scanline_polygon_span_fill_unit #(
  parameter int MAX_EDGES = spf_pkg::MAX_EDGES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  spf_in_if.sink    in_if,
  spf_out_if.source out_if
);
  import spf_pkg::*;

  localparam int IDX_W = $clog2(MAX_EDGES);
  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  spf_cmd_t         cmd;
  spf_stat_t        stat;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] edge_count;

  // sequencer
  spf_ctrl #(.MAX_EDGES(MAX_EDGES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_func    (in_if.func),
    .in_ready   (in_if.ready),
    .edge_count (edge_count),
    .stat       (stat),
    .cmd        (cmd),
    .idx        (idx)
  );

  // datapath
  spf_dpath #(.MAX_EDGES(MAX_EDGES), .IDX_W(IDX_W), .CNT_W(CNT_W)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .idx             (idx),
    .stat            (stat),
    .edge_count      (edge_count),
    .in_edge_lower_y (in_if.edge_lower_y),
    .in_edge_start_x (in_if.edge_start_x),
    .in_edge_upper_y (in_if.edge_upper_y),
    .in_edge_slope   (in_if.edge_slope),
    .in_start_y      (in_if.start_y),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_span_y      (out_if.span_y),
    .out_span_left   (out_if.span_left),
    .out_span_right  (out_if.span_right),
    .out_span_valid  (out_if.span_valid),
    .out_fill_done   (out_if.fill_done)
  );

endmodule

// ===== rtl/spf_checker.sv =====
// ---------------------------------------------------------------------------
// spf_checker: port-level checks of the span fill unit
// Watches the item channels of the top level; attached by bind.
// ---------------------------------------------------------------------------
module spf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [spf_pkg::FUNC_W-1:0]     in_func,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [spf_pkg::X_W-1:0] out_span_left,
  input logic signed [spf_pkg::X_W-1:0] out_span_right,
  input logic                           out_span_valid
);
  import spf_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a step keeps the input closed in the following cycle
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_STEP) |=> !in_ready)
    else $error("item accepted during a step");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // span with fewer than two crossings has zero ends
  a_empty_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_valid |-> (out_span_left == '0) && (out_span_right == '0))
    else $error("empty span with nonzero ends");

  // span ends come in order
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_span_valid |-> out_span_left <= out_span_right)
    else $error("span ends out of order");

endmodule

bind scanline_polygon_span_fill_unit spf_checker u_spf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_func        (in_if.func),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_span_left  (out_if.span_left),
  .out_span_right (out_if.span_right),
  .out_span_valid (out_if.span_valid)
);

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: testbench of the scanline polygon span fill unit
// Drives load, restart and step items with random gaps on both channels,
// predicts every span from its own edge table and active marks, and checks
// each span item field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
  import spf_pkg::*;

  localparam int N_EDGES     = MAX_EDGES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * N_EDGES + 8;
  localparam int RANDOM_ITEMS = 800;

  // item code that the unit ignores
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  typedef struct {
    logic [FUNC_W-1:0]      func;
    logic signed [Y_W-1:0]  edge_lower_y;
    logic signed [X_W-1:0]  edge_start_x;
    logic signed [Y_W-1:0]  edge_upper_y;
    logic signed [DX_W-1:0] edge_slope;
    logic signed [Y_W-1:0]  start_y;
  } fill_item_t;

  typedef struct {
    logic signed [Y_W-1:0] y;
    logic signed [X_W-1:0] left;
    logic signed [X_W-1:0] right;
    logic                  valid;
    logic                  done;
  } span_t;

  logic clk;
  logic rst_n;
  int   fails;
  int   cycle_cnt;
  bit   no_idle;

  spf_in_if  in_ch ();
  spf_out_if out_ch ();

  scanline_polygon_span_fill_unit #(
    .MAX_EDGES(N_EDGES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted edge table and scan state
  logic signed [Y_W-1:0]  tbl_lo_y [N_EDGES];
  logic signed [X_W-1:0]  tbl_x0   [N_EDGES];
  logic signed [Y_W-1:0]  tbl_hi_y [N_EDGES];
  logic signed [DX_W-1:0] tbl_dx   [N_EDGES];
  logic signed [X_W-1:0]  run_x    [N_EDGES];
  bit                     act_mark [N_EDGES];
  int                     n_stored;
  logic signed [Y_W-1:0]  scan_y;
  logic signed [Y_W-1:0]  top_y;

  span_t expected_spans [$];

  // wait length of one side for one item
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 17);
  endfunction

  // track the unit state for one accepted item, queue its span if any
  function automatic void predict_span(input fill_item_t it);
    int    i;
    int    found;
    int    xs [2];
    int    nxt;
    int    acc;
    span_t sp;
    case (it.func)
      FUNC_LOAD: begin
        // table full: item dropped
        if (n_stored < N_EDGES) begin
          tbl_lo_y[n_stored] = it.edge_lower_y;
          tbl_x0[n_stored]   = it.edge_start_x;
          tbl_hi_y[n_stored] = it.edge_upper_y;
          tbl_dx[n_stored]   = it.edge_slope;
          act_mark[n_stored] = 1'b0;
          n_stored++;
        end
      end
      FUNC_RESTART: begin
        scan_y = it.start_y;
        for (i = 0; i < N_EDGES; i++) act_mark[i] = 1'b0;
      end
      FUNC_STEP: begin
        // activate edges starting here, reload x even if already active
        for (i = 0; i < n_stored; i++) begin
          if (tbl_lo_y[i] == scan_y) begin
            act_mark[i] = 1'b1;
            run_x[i]    = tbl_x0[i];
            if (tbl_hi_y[i] > top_y) top_y = tbl_hi_y[i];
          end
        end
        // first two live crossings in table order
        found = 0;
        xs[0] = 0;
        xs[1] = 0;
        for (i = 0; i < n_stored; i++) begin
          if (found < 2 && act_mark[i] && tbl_hi_y[i] > scan_y) begin
            xs[found] = int'(run_x[i]);
            found++;
          end
        end
        sp.y     = scan_y;
        sp.valid = (found == 2);
        sp.left  = '0;
        sp.right = '0;
        if (found == 2) begin
          sp.left  = X_W'((xs[0] < xs[1]) ? xs[0] : xs[1]);
          sp.right = X_W'((xs[0] < xs[1]) ? xs[1] : xs[0]);
        end
        nxt = int'(scan_y);
        nxt = nxt + 1;
        sp.done = (nxt > int'(top_y));
        expected_spans.push_back(sp);
        // advance running x with saturation, then the scanline
        for (i = 0; i < n_stored; i++) begin
          if (act_mark[i]) begin
            acc = int'(run_x[i]);
            acc = acc + int'(tbl_dx[i]);
            if (acc > 131071) acc = 131071;
            if (acc < -131072) acc = -131072;
            run_x[i] = acc[X_W-1:0];
          end
        end
        scan_y = nxt[Y_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // item with every field random
  function automatic fill_item_t random_item(input logic [FUNC_W-1:0] f);
    fill_item_t it;
    it.func         = f;
    it.edge_lower_y = Y_W'($urandom);
    it.edge_start_x = X_W'($urandom);
    it.edge_upper_y = Y_W'($urandom);
    it.edge_slope   = DX_W'($urandom);
    it.start_y      = Y_W'($urandom);
    return it;
  endfunction

  // send one item: gap, then hold until accepted; returns at the accepting edge
  task automatic send_item(input fill_item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.edge_lower_y <= it.edge_lower_y;
    in_ch.edge_start_x <= it.edge_start_x;
    in_ch.edge_upper_y <= it.edge_upper_y;
    in_ch.edge_slope   <= it.edge_slope;
    in_ch.start_y      <= it.start_y;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    @(posedge clk);
    predict_span(it);
  endtask

  task automatic load_edge(input int lo, input int x0, input int hi, input int dx);
    fill_item_t it;
    it              = random_item(FUNC_LOAD);
    it.edge_lower_y = Y_W'(lo);
    it.edge_start_x = X_W'(x0);
    it.edge_upper_y = Y_W'(hi);
    it.edge_slope   = DX_W'(dx);
    send_item(it);
  endtask

  task automatic restart_at(input int y);
    fill_item_t it;
    it         = random_item(FUNC_RESTART);
    it.start_y = Y_W'(y);
    send_item(it);
  endtask

  task automatic step_line();
    send_item(random_item(FUNC_STEP));
  endtask

  // ignored items: unused code, or a load into the full table
  task automatic send_noise();
    send_item(random_item($urandom_range(0, 1) ? FUNC_NONE : FUNC_LOAD));
  endtask

  // empty table, unused code and scanline wrap with nothing stored
  task automatic test_empty_table();
    step_line();
    send_item(random_item(FUNC_NONE));
    restart_at(511);
    step_line();
    step_line();
  endtask

  // single crossing, fresh edge inactive, then a first real span
  task automatic test_partial_table();
    load_edge(-4, 25600, 20, 128);
    restart_at(-4);
    step_line();
    load_edge(-4, 2560, 12, -320);
    restart_at(-4);
    step_line();
    step_line();
  endtask

  // fill the table including field extremes, then loads that are dropped
  task automatic test_table_full();
    fill_item_t it;
    load_edge(-3, -5000, 30, 300);
    load_edge(5, 131000, 40, 65535);
    load_edge(5, -131000, 25, -65536);
    load_edge(511, -131072, 511, -65536);
    load_edge(-512, 131071, -512, 65535);
    load_edge(10, 0, 5, 1234);
    load_edge(-512, -131072, -512, -65536);
    it = random_item(FUNC_LOAD);
    it.edge_lower_y = ~tbl_lo_y[0];
    send_item(it);
  endtask

  // more than two crossings, then saturating edges on their own
  task automatic test_polygon_fill();
    restart_at(-4);
    step_line();
    step_line();
    restart_at(5);
    step_line();
    step_line();
  endtask

  // restart plus a run of steps, with dropped items and broken runs mixed in
  task automatic test_random_spans();
    int sent;
    int run_len;
    int k;
    int y;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
      // most runs restart near the stored edges, some anywhere, some not at all
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          y = $urandom_range(0, 1023);
          y = y - 512;
        end else begin
          y = $urandom_range(0, 60);
          y = y - 10;
        end
        restart_at(y);
        sent++;
      end
      run_len = $urandom_range(1, 40);
      for (k = 0; k < run_len; k++) begin
        if ($urandom_range(0, 15) == 0) send_noise();
        step_line();
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  // scanline wrap with stored edges at both ends of the range
  task automatic test_scanline_wrap();
    int k;
    restart_at(505);
    for (k = 0; k < 24; k++) step_line();
  endtask

  // wait until every predicted span has been checked, then a quiet tail
  task automatic drain_spans();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_spans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_spans.size() != 0) begin
      $error("%0d span items never arrived", expected_spans.size());
      fails++;
    end
  endtask

  // span checker on the result channel
  initial begin : span_checker
    span_t got;
    span_t want;
    int    stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (out_ch.valid !== 1'b1);
      got.y     = out_ch.span_y;
      got.left  = out_ch.span_left;
      got.right = out_ch.span_right;
      got.valid = out_ch.span_valid;
      got.done  = out_ch.fill_done;
      @(posedge clk);
      if (expected_spans.size() == 0) begin
        $error("unexpected span item at span_y %0d", got.y);
        fails++;
      end else begin
        want = expected_spans.pop_front();
        if (got.y !== want.y) begin
          $error("span_y expected %0d got %0d", want.y, got.y);
          fails++;
        end
        if (got.left !== want.left) begin
          $error("span_left expected %0d got %0d", want.left, got.left);
          fails++;
        end
        if (got.right !== want.right) begin
          $error("span_right expected %0d got %0d", want.right, got.right);
          fails++;
        end
        if (got.valid !== want.valid) begin
          $error("span_valid expected %0d got %0d", want.valid, got.valid);
          fails++;
        end
        if (got.done !== want.done) begin
          $error("fill_done expected %0d got %0d", want.done, got.done);
          fails++;
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // reset, test sequence and final verdict
  initial begin : main_seq
    int i;
    fails              = 0;
    no_idle            = 1'b0;
    n_stored           = 0;
    scan_y             = '0;
    top_y              = '0;
    for (i = 0; i < N_EDGES; i++) act_mark[i] = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_LOAD;
    in_ch.edge_lower_y = '0;
    in_ch.edge_start_x = '0;
    in_ch.edge_upper_y = '0;
    in_ch.edge_slope   = '0;
    in_ch.start_y      = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_partial_table();
    test_table_full();
    test_polygon_fill();
    test_random_spans();
    test_scanline_wrap();
    drain_spans();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/spf_pkg.sv
rtl/spf_if.sv
rtl/spf_ctrl.sv
rtl/spf_dpath.sv
rtl/scanline_polygon_span_fill_unit.sv
rtl/spf_checker.sv
dv/tb_top.sv
